// File: rtl/core/pbd_pkg.sv
package pbd_pkg;

    localparam int PAL_ENTRIES     = 256;
    localparam int PAL_AW          = $clog2(PAL_ENTRIES);
    localparam int MAX_SCALE       = 8;
    localparam int MAX_BPP         = 4;
    localparam int MAX_OUT         = 32;
    localparam int COPY_W          = $clog2(MAX_OUT + 1);
    localparam int CNT_W           = $clog2(MAX_OUT);
    localparam int DITHER_STEP     = 64;
    localparam int SUM_W           = 10;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 4;

    localparam logic [7:0] WHITE_BYTE = 8'hFF;
    localparam logic [7:0] BLACK_BYTE = 8'h00;

    localparam logic       OP_PAL_WRITE = 1'b0;
    localparam logic       OP_DITHER    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP   = 1'b1;

    // bayer cell indexed by [column parity][row parity]
    localparam logic [1:0] BAYER_CELL [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

    typedef logic [23:0] pbd_rgb_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [PAL_AW-1:0] addr;
        pbd_rgb_t          data;
    } pbd_mem_req_t;

    // gray = floor(sum / 3) > thr  <=>  sum > 3 * thr + 2
    function automatic logic [SUM_W-1:0] pbd_sum_limit(input logic col, input logic row);
        int thr;
        thr = int'(BAYER_CELL[col][row]) * DITHER_STEP;
        return SUM_W'(3 * thr + 2);
    endfunction

endpackage

// File: rtl/core/pbd_palette.sv
module pbd_palette
    import pbd_pkg::*;
(
    input  logic         aclk,
    input  pbd_mem_req_t req,
    output pbd_rgb_t     rd_data
);

    pbd_rgb_t mem [PAL_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

// File: rtl/core/palette_bayer_dither_top.sv
// Palette lookup and 2x2 ordered dither to a black/white byte stream. A palette
// write item (opcode 0) stores red, green and blue of one entry in an on-chip
// 256 x 24 RAM and gives no output; a pixel item (opcode 1) reads its entry,
// compares (r+g+b)/3 with the bayer threshold picked by column and row parity
// and emits 255 or 0, repeated scale_factor * bytes_per_pixel times (scale
// capped at 8, bytes per pixel at 4), with last_copy on the final byte. Entries
// must be written before they are read; the RAM has no reset. A palette write
// item does not enter the pipeline; a pixel holds the output repeater until its
// last copy is taken, which sets the sustained rate, and its first byte passes
// through the read stage and the output stage registers. The RAM is written and
// read at accept time, so a read straight after a write to the same entry already
// sees the new value. Configuration must be written through the cfg port only
// while the block is idle, which the block does not enforce; cfg_ready is always high.
module palette_bayer_dither_top
    import pbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [7:0]            s_color_index,
    input  logic [7:0]            s_red_level,
    input  logic [7:0]            s_green_level,
    input  logic [7:0]            s_blue_level,
    input  logic                  s_column_odd,
    input  logic                  s_row_odd,
    // result item channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_pixel_byte,
    output logic                  m_last_copy
);

    // configuration registers
    logic [3:0]        scale_reg;
    logic [2:0]        bpp_reg;
    logic [COPY_W-1:0] copies;

    // read stage: palette data arrives from the ram
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_hit_reg;
    logic [SUM_W-1:0]  s1_limit_reg;

    // output stage: the repeater
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_white_reg, s2_white_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              s_accept;
    logic              pix_accept;
    logic              in_range;
    logic              s1_move;
    logic              s1_white;
    logic              s2_load;
    logic              m_accept;
    logic              s2_done;
    logic [SUM_W-1:0]  sum;
    pbd_mem_req_t      mem_req;
    pbd_rgb_t          rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 4'd1;
            bpp_reg   <= 3'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SCALE: scale_reg <= cfg_data;
                REG_BPP:   bpp_reg   <= cfg_data[2:0];
                default:   ;
            endcase
        end
    end

    // copies per pixel, saturated at each factor and at the total
    always_comb begin
        int s_sat;
        int b_sat;
        int n;
        s_sat = (int'(scale_reg) > MAX_SCALE) ? MAX_SCALE : int'(scale_reg);
        b_sat = (int'(bpp_reg) > MAX_BPP) ? MAX_BPP : int'(bpp_reg);
        n     = s_sat * b_sat;
        if (n > MAX_OUT) begin
            n = MAX_OUT;
        end
        copies = COPY_W'(n);
    end

    // handshakes
    assign s_accept   = s_valid && s_ready;
    assign pix_accept = s_accept && (s_opcode == OP_DITHER);
    assign in_range   = (int'(s_color_index) < PAL_ENTRIES);
    assign m_accept   = m_valid && m_ready;
    assign s2_done    = m_accept && m_last_copy;

    // a pixel with no copies leaves the read stage without touching the repeater
    assign s1_move = s1_valid_reg && ((copies == '0) || !s2_valid_reg || s2_done);
    assign s2_load = s1_move && (copies != '0);
    assign s_ready = !s1_valid_reg || s1_move;

    // palette ram: writes and reads both happen when the item is taken
    always_comb begin
        mem_req.wr_en = s_accept && (s_opcode == OP_PAL_WRITE) && in_range;
        mem_req.rd_en = pix_accept && in_range;
        mem_req.addr  = s_color_index[PAL_AW-1:0];
        mem_req.data  = {s_red_level, s_green_level, s_blue_level};
    end

    pbd_palette u_palette (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // gray compare without a divider, against the precomputed sum limit
    assign sum      = SUM_W'(rd_data[23:16]) + SUM_W'(rd_data[15:8]) + SUM_W'(rd_data[7:0]);
    assign s1_white = s1_hit_reg && (sum > s1_limit_reg);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_ready) begin
            s1_valid_next = pix_accept;
        end
    end

    // repeater: a fresh pixel is loaded in the cycle its predecessor's last copy goes
    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_white_next = s2_white_reg;
        cnt_next      = cnt_reg;
        priority if (s2_load) begin
            s2_valid_next = 1'b1;
            s2_white_next = s1_white;
            cnt_next      = '0;
        end else if (s2_done) begin
            s2_valid_next = 1'b0;
        end else if (m_accept) begin
            cnt_next      = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            s1_hit_reg   <= in_range;
            s1_limit_reg <= pbd_sum_limit(s_column_odd, s_row_odd);
        end
        s2_white_reg <= s2_white_next;
        cnt_reg      <= cnt_next;
    end

    assign m_valid      = s2_valid_reg;
    assign m_pixel_byte = s2_white_reg ? WHITE_BYTE : BLACK_BYTE;
    assign m_last_copy  = (COPY_W'(cnt_reg) + COPY_W'(1)) == copies;

    // copy counter never runs past the configured count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((COPY_W + 1)'(cnt_reg) < (COPY_W + 1)'(copies)))
        else $error("copy counter beyond copy count");

    // an accepted pixel is in the read stage on the next cycle
    a_pix_to_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_accept |=> s1_valid_reg)
        else $error("accepted pixel missing from read stage");

    // ram read data holds while the read stage is stalled
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(rd_data)))
        else $error("palette read data lost during stall");

    // a repeated byte keeps its colour until the last copy is taken
    a_byte_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && !m_last_copy) |=> (m_valid && $stable(m_pixel_byte)))
        else $error("pixel byte changed within one pixel");

endmodule

// File: verif/pbd_tb_pkg.sv
`timescale 1ns / 100ps
package pbd_tb_pkg;
    import pbd_pkg::*;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       last_copy;
    } dither_byte_t;

    class dither_scoreboard;
        pbd_rgb_t     palette_copy [PAL_ENTRIES];
        logic [3:0]   scale_reg;
        logic [2:0]   bpp_reg;
        dither_byte_t pending_bytes [$];
        int           mismatch_count;

        function new();
            scale_reg      = 4'd1;
            bpp_reg        = 3'd1;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] reg_index,
                                logic [CFG_DATA_W-1:0] reg_data);
            case (reg_index)
                REG_SCALE: scale_reg = reg_data;
                REG_BPP:   bpp_reg   = reg_data[2:0];
                default: ;
            endcase
        endfunction

        // works out the bytes one accepted item gives
        function void note_item(logic opcode, logic [7:0] color_index,
                                logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                logic column_odd, logic row_odd);
            pbd_rgb_t     rgb;
            int           level_sum;
            int           threshold;
            int           reps;
            int           depth;
            int           copies;
            int           k;
            dither_byte_t want;
            if (opcode == OP_PAL_WRITE) begin
                palette_copy[color_index] = {red, green, blue};
                return;
            end
            rgb       = palette_copy[color_index];
            level_sum = int'(rgb[23:16]) + int'(rgb[15:8]) + int'(rgb[7:0]);
            case ({column_odd, row_odd})
                2'b00:   threshold = 0;
                2'b01:   threshold = 2 * DITHER_STEP;
                2'b10:   threshold = 3 * DITHER_STEP;
                default: threshold = DITHER_STEP;
            endcase
            want.pixel_byte = (level_sum / 3 > threshold) ? WHITE_BYTE : BLACK_BYTE;
            reps   = (int'(scale_reg) > MAX_SCALE) ? MAX_SCALE : int'(scale_reg);
            depth  = (int'(bpp_reg) > MAX_BPP) ? MAX_BPP : int'(bpp_reg);
            copies = reps * depth;
            if (copies > MAX_OUT)
                copies = MAX_OUT;
            for (k = 0; k < copies; k++) begin
                want.last_copy = (k + 1 == copies);
                pending_bytes.push_back(want);
            end
        endfunction

        function void check_result(logic [7:0] pixel_byte, logic last_copy);
            dither_byte_t want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected item: pixel_byte %0d last_copy %0d", pixel_byte, last_copy);
                mismatch_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (pixel_byte !== want.pixel_byte) begin
                $error("pixel_byte: expected %0d, got %0d", want.pixel_byte, pixel_byte);
                mismatch_count++;
            end
            if (last_copy !== want.last_copy) begin
                $error("last_copy: expected %0d, got %0d", want.last_copy, last_copy);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        function void close_out();
            if (pending_bytes.size() != 0) begin
                $error("%0d expected items never arrived", pending_bytes.size());
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

// File: verif/palette_bayer_dither_top_tb.sv
`timescale 1ns / 100ps
module palette_bayer_dither_top_tb;
    import pbd_pkg::*;
    import pbd_tb_pkg::*;

    localparam int RUN_LIMIT     = 400000;  // cycles before giving up
    localparam int SETTLE_CYCLES = 8;       // idle margin before a register write
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int END_CYCLES    = 40;      // tail after the last expected item

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [7:0]            s_color_index;
    logic [7:0]            s_red_level;
    logic [7:0]            s_green_level;
    logic [7:0]            s_blue_level;
    logic                  s_column_odd;
    logic                  s_row_odd;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_pixel_byte;
    logic                  m_last_copy;

    dither_scoreboard sb;

    // traffic shaping flags, set by the main sequence and read by the driver and the receiver
    bit no_idle;      // neither side idles
    bit sender_keen;  // sender offers back to back
    bit stall_req;    // ask the receiver for one long hold-off
    int cycle_count;

    // palette entries written so far, so that no pixel reads an empty entry
    bit         entry_written [PAL_ENTRIES];
    logic [7:0] written_idx [$];

    palette_bayer_dither_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_color_index (s_color_index),
        .s_red_level   (s_red_level),
        .s_green_level (s_green_level),
        .s_blue_level  (s_blue_level),
        .s_column_odd  (s_column_odd),
        .s_row_odd     (s_row_odd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_byte  (m_pixel_byte),
        .m_last_copy   (m_last_copy)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: random back-pressure, an occasional long hold-off,
    // and full speed while no_idle is set
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever @(posedge aclk) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // every accepted output item goes straight to the scoreboard
    initial begin
        forever @(posedge aclk) begin
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_pixel_byte, m_last_copy);
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one item; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic opcode, input logic [7:0] color_index,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic column_odd,
                             input logic row_odd);
        while (!(no_idle || sender_keen) && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= opcode;
        s_color_index <= color_index;
        s_red_level   <= red;
        s_green_level <= green;
        s_blue_level  <= blue;
        s_column_odd  <= column_odd;
        s_row_odd     <= row_odd;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(opcode, color_index, red, green, blue, column_odd, row_odd);
    endtask

    // palette write; parities are don't-care, so randomise them
    task automatic write_entry(input logic [7:0] color_index, input logic [7:0] red,
                               input logic [7:0] green, input logic [7:0] blue);
        send_item(OP_PAL_WRITE, color_index, red, green, blue,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (!entry_written[color_index]) begin
            entry_written[color_index] = 1'b1;
            written_idx.push_back(color_index);
        end
    endtask

    // pixel item; the colour levels are ignored by the block, so randomise them
    task automatic send_pixel(input logic [7:0] color_index, input logic column_odd,
                              input logic row_odd);
        send_item(OP_DITHER, color_index, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  column_odd, row_odd);
    endtask

    // drop valid and wait until every expected byte is out, plus a margin
    // for pixels with no copies still inside the block
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers back to back; valid stays up between the two
    task automatic set_config(input logic [CFG_DATA_W-1:0] scale,
                              input logic [CFG_DATA_W-1:0] bpp);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCALE;
        cfg_data  <= scale;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(REG_SCALE, scale);
        cfg_index <= REG_BPP;
        cfg_data  <= bpp;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(REG_BPP, bpp);
        cfg_valid <= 1'b0;
    endtask

    // mostly pixels from written entries, with palette writes mixed in
    task automatic random_items(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 25)
                write_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                send_pixel(written_idx[$urandom_range(0, written_idx.size() - 1)],
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] scale,
                             input logic [CFG_DATA_W-1:0] bpp, input int count);
        drain();
        set_config(scale, bpp);
        random_items(count);
    endtask

    initial begin
        int p;
        sb          = new();
        no_idle     = 1'b0;
        sender_keen = 1'b0;
        stall_req   = 1'b0;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_SCALE;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_PAL_WRITE;
        s_color_index <= '0;
        s_red_level   <= '0;
        s_green_level <= '0;
        s_blue_level  <= '0;
        s_column_odd  <= 1'b0;
        s_row_odd     <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset setting of one copy per pixel
        write_entry(8'd0, 8'd0, 8'd0, 8'd0);          // black everywhere
        write_entry(8'd255, 8'd255, 8'd255, 8'd255);  // white everywhere
        write_entry(8'd1, 8'd255, 8'd0, 8'd0);        // gray 85, single channels
        write_entry(8'd2, 8'd0, 8'd255, 8'd0);
        write_entry(8'd3, 8'd0, 8'd0, 8'd255);
        write_entry(8'd4, 8'd64, 8'd64, 8'd64);       // gray on the 64 threshold
        write_entry(8'd5, 8'd65, 8'd65, 8'd65);       // one above it
        for (p = 0; p < 4; p++) begin
            send_pixel(8'd0, p[1], p[0]);
            send_pixel(8'd255, p[1], p[0]);
        end
        send_pixel(8'd4, 1'b1, 1'b1);
        send_pixel(8'd5, 1'b1, 1'b1);
        send_pixel(8'd1, 1'b0, 1'b0);
        send_pixel(8'd2, 1'b0, 1'b1);
        send_pixel(8'd3, 1'b1, 1'b1);
        // rounding of the sum just under and over the 192 threshold,
        // each read straight after its write
        write_entry(8'd6, 8'd193, 8'd192, 8'd192);
        send_pixel(8'd6, 1'b1, 1'b0);
        write_entry(8'd128, 8'd193, 8'd193, 8'd193);
        send_pixel(8'd128, 1'b1, 1'b0);

        // usual four bytes per pixel, with the receiver held off for a long
        // stretch while the sender keeps offering
        run_phase(4'd1, 4'd4, 15);
        stall_req   = 1'b1;
        sender_keen = 1'b1;
        random_items(40);
        sender_keen = 1'b0;
        random_items(15);

        run_phase(4'd8, 4'd4, 25);   // largest legal count, 32 copies
        run_phase(4'd15, 4'd7, 15);  // oversize fields saturate to 32 copies
        run_phase(4'd0, 4'd5, 20);   // zero scale, no output at all
        run_phase(4'd6, 4'd8, 20);   // bytes per pixel masks to zero

        // full-speed stretch, then a sender pause until everything is out
        run_phase(4'd2, 4'd2, 0);
        no_idle = 1'b1;
        random_items(40);
        no_idle = 1'b0;
        random_items(15);
        drain();
        random_items(20);

        run_phase(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 7)), 40);
        run_phase(4'd1, 4'd1, 50);

        drain();
        repeat (END_CYCLES) @(posedge aclk);
        sb.close_out();
        if (sb.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
